/* hw/rtl/lpm_pkg.sv */
`default_nettype none

package lpm_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int LEN_W = 5;
	localparam int LINE_W = 32;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = 2;
	localparam int RQ_CNT_W = 3;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [LINE_W-1:0] SHOWN_MAX = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_IGNORE_CASE    = 3'd3,
		REG_COUNT_ONLY     = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		KIND_LINE    = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// Match settings seen by the window compare.
	typedef struct packed {
		logic [8*PATTERN_BYTES-1:0] pattern;
		logic [LEN_W-1:0]           length;
		logic                       fold_en;
	} match_cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [LINE_W-1:0] line;
		logic [LINE_W-1:0] count;
		logic              last;
	} result_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpm_window.sv */
`default_nettype none

module lpm_window #(
	parameter int MAX_PATTERN = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          data,
	input  wire logic                eol,
	input  wire lpm_pkg::match_cfg_t cfg,
	output logic                     match
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	logic [7:0]        win_q [MAX_PATTERN];
	logic [7:0]        shifted [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [MAX_PATTERN-1:0] slot_ok;
	logic              len_ok;
	logic              fill_ok;

	// Newest byte enters slot 0.
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_shift
		if (j == 0) begin : g_head
			assign shifted[j] = data;
		end else begin : g_tail
			assign shifted[j] = win_q[j-1];
		end
	end

	assign fill_next = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + FILL_W'(1);

	// Slot j lines up with pattern byte (length - 1 - j).
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
		logic [lpm_pkg::LEN_W-1:0] pidx;
		logic [7:0]                pbyte;
		assign pidx  = cfg.length - lpm_pkg::LEN_W'(1) - lpm_pkg::LEN_W'(j);
		assign pbyte = cfg.pattern[pidx[3:0]*8 +: 8];
		assign slot_ok[j] = (lpm_pkg::LEN_W'(j) >= cfg.length) ||
			(lpm_pkg::fold_byte(shifted[j], cfg.fold_en) ==
			 lpm_pkg::fold_byte(pbyte, cfg.fold_en));
	end

	assign len_ok  = (cfg.length != '0) && (cfg.length <= lpm_pkg::LEN_W'(MAX_PATTERN));
	assign fill_ok = lpm_pkg::LEN_W'(fill_next) >= cfg.length;
	assign match   = len_ok && fill_ok && (&slot_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step) begin
			fill_q <= eol ? '0 : fill_next;
		end
	end

	// Window bytes past the fill count are never compared, so no reset.
	always_ff @(posedge clk) begin
		if (step && !eol) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_q[j] <= shifted[j];
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lpm_fifo.sv */
`default_nettype none

module lpm_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [1:0]       push_cnt,
	input  wire lpm_pkg::result_t d0,
	input  wire lpm_pkg::result_t d1,
	input  wire logic             pop,
	output logic                  valid,
	output lpm_pkg::result_t      dout,
	output logic                  room2
);

	lpm_pkg::result_t               mem_q [lpm_pkg::RQ_DEPTH];
	logic [lpm_pkg::RQ_PTR_W-1:0]   wr_q;
	logic [lpm_pkg::RQ_PTR_W-1:0]   rd_q;
	logic [lpm_pkg::RQ_CNT_W-1:0]   cnt_q;
	logic                           do_pop;

	assign valid  = cnt_q != '0;
	assign dout   = mem_q[rd_q];
	assign room2  = cnt_q <= lpm_pkg::RQ_CNT_W'(lpm_pkg::RQ_DEPTH - 2);
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + lpm_pkg::RQ_PTR_W'(push_cnt);
			rd_q  <= rd_q + lpm_pkg::RQ_PTR_W'(do_pop);
			cnt_q <= cnt_q + lpm_pkg::RQ_CNT_W'(push_cnt) - lpm_pkg::RQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + lpm_pkg::RQ_PTR_W'(1)] <= d1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lpm_pkg::RQ_CNT_W'(lpm_pkg::RQ_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room2)
		else $error("push into result queue without room");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* hw/rtl/line_pattern_matcher.sv */
`default_nettype none

// A byte accepted into the input register is matched there; its results enter the
//   result queue once the queue has room for two beats; out_valid rises after it.
// Throughput: one byte per cycle while the result queue has room for two beats; the
//   queue drains one beat per cycle with out_ready high, so a run of bytes that each
//   end a matching line and the document (two beats) is held back by that drain.
// Reset (arst_n low, async): config to defaults (length 1), line number 1, count 0.
module line_pattern_matcher #(
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_BITS  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// byte input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            end_of_document,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 result_kind,
	output logic [lpm_pkg::LINE_W-1:0]           line_number,
	output logic [lpm_pkg::LINE_W-1:0]           match_count,
	output logic                                 last_of_run,
	// configuration writes
	input  wire logic                            cfg_write,
	input  wire logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lpm_pkg::CFG_W-1:0]       cfg_data
);

	// Shown count is clipped to 32 bits; widen so the compare is legal for any width.
	localparam int CNT_EXT_W = (COUNT_BITS > lpm_pkg::LINE_W) ? COUNT_BITS : lpm_pkg::LINE_W;

	// ---------------- configuration registers ----------------
	logic [lpm_pkg::CFG_W-1:0] pat_lo_q;
	logic [lpm_pkg::CFG_W-1:0] pat_hi_q;
	logic [lpm_pkg::LEN_W-1:0] pat_len_q;
	logic                      fold_en_q;
	logic                      count_only_q;
	lpm_pkg::match_cfg_t       mcfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q      <= '0;
			pat_hi_q      <= '0;
			pat_len_q     <= lpm_pkg::LEN_W'(1);
			fold_en_q     <= 1'b0;
			count_only_q  <= 1'b0;
		end else if (cfg_write) begin
			case (lpm_pkg::cfg_reg_t'(cfg_index))
				lpm_pkg::REG_PATTERN_LOW:    pat_lo_q      <= cfg_data;
				lpm_pkg::REG_PATTERN_HIGH:   pat_hi_q      <= cfg_data;
				lpm_pkg::REG_PATTERN_LENGTH: pat_len_q     <= cfg_data[lpm_pkg::LEN_W-1:0];
				lpm_pkg::REG_IGNORE_CASE:    fold_en_q     <= cfg_data[0];
				lpm_pkg::REG_COUNT_ONLY:     count_only_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign mcfg.pattern     = {pat_hi_q, pat_lo_q};
	assign mcfg.length      = pat_len_q;
	assign mcfg.fold_en     = fold_en_q;

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;
	logic       room2;
	logic       adv;   // the held byte is processed this cycle

	assign adv      = valid_s1 && room2;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_document;
		end
	end

	// ---------------- window and compare ----------------
	logic is_lf;
	logic is_cr;
	logic eol;
	logic win_match;

	assign is_lf    = byte_s1 == lpm_pkg::CHAR_LF;
	assign is_cr    = byte_s1 == lpm_pkg::CHAR_CR;
	assign eol      = is_lf || eod_s1;

	lpm_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.data    (byte_s1),
		.eol     (eol),
		.cfg     (mcfg),
		.match   (win_match)
	);

	// ---------------- line bookkeeping ----------------
	logic                        has_q;      // line already holds a match
	logic                        cr_q;       // match ended on a CR that may be stripped
	logic [lpm_pkg::LINE_W-1:0]  line_q;
	logic [COUNT_BITS-1:0]       count_q;

	logic                        has_n;
	logic                        cr_n;
	logic                        hit;
	logic                        report;
	logic [COUNT_BITS-1:0]       count_n;
	logic [CNT_EXT_W-1:0]        count_ext;
	logic [lpm_pkg::LINE_W-1:0]  shown;

	always_comb begin
		has_n = has_q;
		cr_n  = cr_q;
		if (!is_lf) begin
			// a CR match only counts once another byte stays in the line
			if (is_cr) begin
				has_n = has_q || cr_q;
				cr_n  = win_match;
			end else begin
				has_n = has_q || cr_q || win_match;
				cr_n  = 1'b0;
			end
		end
	end

	assign hit     = eol && has_n;
	assign report  = hit && !count_only_q;
	assign count_n = (hit && (count_q != '1)) ? count_q + COUNT_BITS'(1) : count_q;

	assign count_ext = CNT_EXT_W'(count_n);
	assign shown     = (count_ext > CNT_EXT_W'(lpm_pkg::SHOWN_MAX)) ?
		lpm_pkg::SHOWN_MAX : count_ext[lpm_pkg::LINE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q   <= 1'b0;
			cr_q    <= 1'b0;
			line_q  <= lpm_pkg::LINE_W'(1);
			count_q <= '0;
		end else if (adv) begin
			if (eol) begin
				has_q <= 1'b0;
				cr_q  <= 1'b0;
			end else begin
				has_q <= has_n;
				cr_q  <= cr_n;
			end
			if (eod_s1) begin
				line_q  <= lpm_pkg::LINE_W'(1);
				count_q <= '0;
			end else begin
				if (eol && (line_q != '1)) begin
					line_q <= line_q + lpm_pkg::LINE_W'(1);
				end
				count_q <= count_n;
			end
		end
	end

	// ---------------- result assembly ----------------
	// Line report goes first when a byte ends both a matching line and the document.
	lpm_pkg::result_t rep_beat;
	lpm_pkg::result_t sum_beat;
	lpm_pkg::result_t d0;
	logic [1:0]       push_cnt;
	lpm_pkg::result_t head;

	assign rep_beat.kind  = lpm_pkg::KIND_LINE;
	assign rep_beat.line  = line_q;
	assign rep_beat.count = shown;
	assign rep_beat.last  = !eod_s1;

	assign sum_beat.kind  = lpm_pkg::KIND_SUMMARY;
	assign sum_beat.line  = '0;
	assign sum_beat.count = shown;
	assign sum_beat.last  = 1'b1;

	assign d0       = report ? rep_beat : sum_beat;
	assign push_cnt = adv ? (2'(report) + 2'(eod_s1)) : 2'd0;

	lpm_fifo u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_cnt(push_cnt),
		.d0      (d0),
		.d1      (sum_beat),
		.pop     (out_ready),
		.valid   (out_valid),
		.dout    (head),
		.room2   (room2)
	);

	assign result_kind = head.kind;
	assign line_number = head.line;
	assign match_count = head.count;
	assign last_of_run = head.last;

	// ---------------- checks ----------------
	a_sum_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == lpm_pkg::KIND_SUMMARY)) |-> (line_number == '0))
		else $error("summary beat with nonzero line number");

	a_report_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == lpm_pkg::KIND_LINE)) |-> (match_count != '0))
		else $error("line report with zero match count");

	a_not_last_is_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> (result_kind == lpm_pkg::KIND_LINE))
		else $error("summary beat not marked last");

	a_doc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eod_s1) |=> ((line_q == lpm_pkg::LINE_W'(1)) && (count_q == '0)))
		else $error("counters not restarted after document end");

endmodule

`default_nettype wire
